### rtl/assert_macros.svh
// assertion macros shared by the encoder rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked outside reset
`define BV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication, checked outside reset
`define BV_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/bvenc_pkg.sv
// shared types, constants and helpers of the ber value encoder
// no dependencies
package bvenc_pkg;

  localparam int unsigned MAX_SUBIDS_DEF = 12;
  localparam int unsigned SUBID_CNT_W    = 4;
  localparam int unsigned CMDQ_DEPTH     = 2;
  localparam int unsigned OID_LEN_W      = 7;

  localparam logic [1:0] REQ_SINT = 2'd0;
  localparam logic [1:0] REQ_UINT = 2'd1;
  localparam logic [1:0] REQ_OID  = 2'd2;
  localparam logic [1:0] REQ_STR  = 2'd3;

  localparam logic [7:0] TAG_INT    = 8'h02;
  localparam logic [7:0] TAG_OCTETS = 8'h04;
  localparam logic [7:0] TAG_OID    = 8'h06;
  localparam logic [7:0] LEN_LONG1  = 8'h81;
  localparam logic [7:0] LEN_LONG2  = 8'h82;
  localparam logic [7:0] GRP_MORE   = 8'h80;
  localparam logic [7:0] OID_MUL    = 8'd40;

  // one queued element: tag byte, then nb bytes from the top of word,
  // then base-128 groups of stored subids 2..cnt-1 when oid is set
  typedef struct packed {
    logic                   oid;
    logic                   err;
    logic [7:0]             tag;
    logic [39:0]            word;
    logic [2:0]             nb;
    logic [SUBID_CNT_W-1:0] cnt;
  } cmd_t;

  // number of base-128 groups of a subidentifier
  function automatic logic [2:0] subid_groups(input logic [31:0] v);
    logic [2:0] g;
    if (|v[31:28])      g = 3'd5;
    else if (|v[27:21]) g = 3'd4;
    else if (|v[20:14]) g = 3'd3;
    else if (|v[13:7])  g = 3'd2;
    else                g = 3'd1;
    return g;
  endfunction

endpackage

### rtl/ber_value_encoder_unit.sv
// top level of the ber tlv value encoder
// depends on bvenc_pkg, bvenc_front, bvenc_cmd_fifo, bvenc_ram, bvenc_back
//
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_ready_o   req_type_i value_i type_tag_i last_subid_i
// out      output     out_valid_o / out_ready_i out_byte_o last_o error_o
//
// the front takes one request per cycle while the command queue has room;
// a scalar element then leaves as tag, length and 1..4 value bytes (a string
// as tag and length, an error as tag alone), one byte per cycle from the output
// register unless stalled. an oid: tag, length, first-subid byte, then per later
// subid a store read and 1..5 groups; subids of a new oid wait until it is out.
// reset clears control state only; the subid store needs no clearing.
// a stalled output holds the back, the queue then fills and stops the front.
module ber_value_encoder_unit #(
  parameter int unsigned MaxSubids = bvenc_pkg::MAX_SUBIDS_DEF,
  localparam int unsigned Aw       = (MaxSubids > 1) ? $clog2(MaxSubids) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] value_i,
  input  logic [7:0]  type_tag_i,
  input  logic        last_subid_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic        error_o
);
  import bvenc_pkg::*;

  cmd_t          push_data, pop_data;
  logic          push, full, pop, q_valid;
  logic          ram_we;
  logic [Aw-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;
  logic          oid_done;

  bvenc_front #(
    .MaxSubids(MaxSubids)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .type_tag_i  (type_tag_i),
    .last_subid_i(last_subid_i),
    .q_push_o    (push),
    .q_data_o    (push_data),
    .q_full_i    (full),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .oid_done_i  (oid_done)
  );

  bvenc_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .data_o     (pop_data)
  );

  bvenc_ram #(
    .Width(32),
    .Depth(MaxSubids)
  ) u_subid_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  bvenc_back #(
    .MaxSubids(MaxSubids)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (pop_data),
    .q_pop_o    (pop),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .oid_done_o (oid_done),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .last_o     (last_o),
    .error_o    (error_o)
  );

endmodule

### rtl/bvenc_ram.sv
// generic single write port ram with registered read
// no dependencies
module bvenc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 12,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/bvenc_cmd_fifo.sv
// short command queue between the front and the back of the encoder
// depends on bvenc_pkg
module bvenc_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bvenc_pkg::cmd_t   push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output bvenc_pkg::cmd_t   data_o
);
  import bvenc_pkg::*;

  localparam int unsigned Pw = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned Cw = $clog2(CMDQ_DEPTH + 1);

  cmd_t          entry_q [CMDQ_DEPTH];
  logic [Pw-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [Cw-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == Cw'(CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == Pw'(CMDQ_DEPTH - 1)) ? '0 : wptr_q + Pw'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == Pw'(CMDQ_DEPTH - 1)) ? '0 : rptr_q + Pw'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + Cw'(1);
      2'b01:   cnt_d = cnt_q - Cw'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/bvenc_front.sv
// front end: accepts requests, sizes scalars, collects oid subids
// depends on bvenc_pkg and assert_macros.svh
`include "assert_macros.svh"
module bvenc_front #(
  parameter int unsigned MaxSubids = bvenc_pkg::MAX_SUBIDS_DEF,
  localparam int unsigned Aw       = (MaxSubids > 1) ? $clog2(MaxSubids) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [31:0]       value_i,
  input  logic [7:0]        type_tag_i,
  input  logic              last_subid_i,
  output logic              q_push_o,
  output bvenc_pkg::cmd_t   q_data_o,
  input  logic              q_full_i,
  output logic              ram_we_o,
  output logic [Aw-1:0]     ram_waddr_o,
  output logic [31:0]       ram_wdata_o,
  input  logic              oid_done_i
);
  import bvenc_pkg::*;

  logic [SUBID_CNT_W-1:0] cnt_q, cnt_d;
  logic                   ovf_q, ovf_d;
  logic [7:0]             fs_q, fs_d;
  logic [OID_LEN_W-1:0]   olen_q, olen_d;
  logic                   busy_q, busy_d;

  logic        fire, store;
  logic [2:0]  slen, ulen, sc_len;
  logic [31:0] sc_data;
  logic [15:0] fs_prod;
  logic        ovf_n;
  logic [7:0]  fs_n;
  logic [OID_LEN_W-1:0]   olen_n;
  logic [SUBID_CNT_W-1:0] cnt_n;
  cmd_t        cmd;

  // an oid subid must not overwrite the store while the back still reads it
  assign in_ready_o = !q_full_i && !(req_type_i == REQ_OID && busy_q);
  assign fire       = in_valid_i && in_ready_o;
  assign store      = (cnt_q < SUBID_CNT_W'(MaxSubids));
  assign fs_prod    = value_i[7:0] * OID_MUL;

  assign ram_we_o    = fire && (req_type_i == REQ_OID) && store;
  assign ram_waddr_o = cnt_q[Aw-1:0];
  assign ram_wdata_o = value_i;

  always_comb begin
    if (value_i[31:23] != {9{value_i[31]}})      slen = 3'd4;
    else if (value_i[31:15] != {17{value_i[31]}}) slen = 3'd3;
    else if (value_i[31:7] != {25{value_i[31]}})  slen = 3'd2;
    else                                          slen = 3'd1;

    if (|value_i[31:24])      ulen = 3'd4;
    else if (|value_i[23:16]) ulen = 3'd3;
    else if (|value_i[15:8])  ulen = 3'd2;
    else                      ulen = 3'd1;

    sc_len = (req_type_i == REQ_SINT) ? slen : ulen;
    case (sc_len)
      3'd1:    sc_data = {value_i[7:0], 24'd0};
      3'd2:    sc_data = {value_i[15:0], 16'd0};
      3'd3:    sc_data = {value_i[23:0], 8'd0};
      default: sc_data = value_i;
    endcase
  end

  // oid collection: the first two subids fold into one byte, later ones
  // add their group count to the content length
  always_comb begin
    fs_n   = fs_q;
    olen_n = olen_q;
    cnt_n  = cnt_q;
    ovf_n  = ovf_q;
    if (store) begin
      cnt_n = cnt_q + SUBID_CNT_W'(1);
      if (cnt_q == SUBID_CNT_W'(0)) begin
        fs_n = fs_prod[7:0];
      end else if (cnt_q == SUBID_CNT_W'(1)) begin
        fs_n = fs_q + value_i[7:0];
      end else begin
        olen_n = olen_q + OID_LEN_W'(subid_groups(value_i));
      end
    end else begin
      ovf_n = 1'b1;
    end
  end

  always_comb begin
    cmd      = '0;
    q_push_o = 1'b0;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    fs_d     = fs_q;
    olen_d   = olen_q;
    busy_d   = busy_q && !oid_done_i;
    case (req_type_i)
      REQ_SINT, REQ_UINT: begin
        q_push_o = fire;
        cmd.tag  = (req_type_i == REQ_SINT) ? TAG_INT : type_tag_i;
        cmd.word = {5'd0, sc_len, sc_data};
        cmd.nb   = sc_len + 3'd1;
      end
      REQ_STR: begin
        q_push_o = fire;
        cmd.tag  = TAG_OCTETS;
        if (|value_i[31:16]) begin
          cmd.err = 1'b1;
        end else if (|value_i[15:8]) begin
          cmd.word = {LEN_LONG2, value_i[15:0], 16'd0};
          cmd.nb   = 3'd3;
        end else if (value_i[7]) begin
          cmd.word = {LEN_LONG1, value_i[7:0], 24'd0};
          cmd.nb   = 3'd2;
        end else begin
          cmd.word = {value_i[7:0], 32'd0};
          cmd.nb   = 3'd1;
        end
      end
      REQ_OID: begin
        cmd.tag = TAG_OID;
        if (fire) begin
          if (last_subid_i) begin
            q_push_o = 1'b1;
            if (ovf_n) begin
              cmd.err = 1'b1;
            end else begin
              cmd.oid  = 1'b1;
              cmd.word = {{(8 - OID_LEN_W){1'b0}}, olen_n, fs_n, 24'd0};
              cmd.nb   = 3'd2;
              cmd.cnt  = cnt_n;
              busy_d   = 1'b1;
            end
            cnt_d  = '0;
            ovf_d  = 1'b0;
            fs_d   = '0;
            olen_d = OID_LEN_W'(1);
          end else begin
            cnt_d  = cnt_n;
            ovf_d  = ovf_n;
            fs_d   = fs_n;
            olen_d = olen_n;
          end
        end
      end
      default: cmd = '0;
    endcase
  end

  assign q_data_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      fs_q   <= '0;
      olen_q <= OID_LEN_W'(1);
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      fs_q   <= fs_d;
      olen_q <= olen_d;
      busy_q <= busy_d;
    end
  end

  `BV_ASSERT(a_cnt_bound, cnt_q <= SUBID_CNT_W'(MaxSubids), "subid count beyond store depth")
  `BV_ASSERT_IMPL(a_wr_idle, ram_we_o, !busy_q, "subid store written during oid emission")

endmodule

### rtl/bvenc_back.sv
// back end: turns queued commands into one byte per transfer
// depends on bvenc_pkg and assert_macros.svh
`include "assert_macros.svh"
module bvenc_back #(
  parameter int unsigned MaxSubids = bvenc_pkg::MAX_SUBIDS_DEF,
  localparam int unsigned Aw       = (MaxSubids > 1) ? $clog2(MaxSubids) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  bvenc_pkg::cmd_t   q_data_i,
  output logic              q_pop_o,
  output logic [Aw-1:0]     ram_raddr_o,
  input  logic [31:0]       ram_rdata_i,
  output logic              oid_done_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              last_o,
  output logic              error_o
);
  import bvenc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_HEAD = 4'b0010,
    S_RD   = 4'b0100,
    S_GRP  = 4'b1000
  } bstate_e;

  bstate_e                state_q, state_d;
  logic [39:0]            word_q, word_d;
  logic [2:0]             nb_q, nb_d;
  logic                   oid_q, oid_d;
  logic [SUBID_CNT_W-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic [31:0]            val_q, val_d;
  logic [2:0]             grp_q, grp_d;
  logic                   ov_q, ov_d, ol_q, ol_d, oe_q, oe_d;
  logic [7:0]             ob_q, ob_d;

  logic                   adv, emit, e_last, e_err, more_oid;
  logic [7:0]             e_byte, grp_bits;
  logic [SUBID_CNT_W-1:0] idx_nx;

  // output slot is free or being drained this cycle
  assign adv      = !ov_q || out_ready_i;
  assign more_oid = oid_q && (cnt_q > SUBID_CNT_W'(2));
  assign idx_nx   = idx_q + SUBID_CNT_W'(1);

  always_comb begin
    case (grp_q)
      3'd1:    grp_bits = {1'b0, val_q[6:0]};
      3'd2:    grp_bits = {1'b0, val_q[13:7]};
      3'd3:    grp_bits = {1'b0, val_q[20:14]};
      3'd4:    grp_bits = {1'b0, val_q[27:21]};
      3'd5:    grp_bits = {4'd0, val_q[31:28]};
      default: grp_bits = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    word_d  = word_q;
    nb_d    = nb_q;
    oid_d   = oid_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    val_d   = val_q;
    grp_d   = grp_q;
    q_pop_o = 1'b0;
    emit    = 1'b0;
    e_byte  = '0;
    e_last  = 1'b0;
    e_err   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i && adv) begin
          q_pop_o = 1'b1;
          emit    = 1'b1;
          e_byte  = q_data_i.tag;
          e_last  = (q_data_i.nb == 3'd0);
          e_err   = q_data_i.err;
          word_d  = q_data_i.word;
          nb_d    = q_data_i.nb;
          oid_d   = q_data_i.oid;
          cnt_d   = q_data_i.cnt;
          state_d = (q_data_i.nb == 3'd0) ? S_IDLE : S_HEAD;
        end
      end
      S_HEAD: begin
        if (adv) begin
          emit   = 1'b1;
          e_byte = word_q[39:32];
          e_last = (nb_q == 3'd1) && !more_oid;
          word_d = {word_q[31:0], 8'd0};
          nb_d   = nb_q - 3'd1;
          if (nb_q == 3'd1) begin
            if (more_oid) begin
              idx_d   = SUBID_CNT_W'(2);
              state_d = S_RD;
            end else begin
              state_d = S_IDLE;
            end
          end
        end
      end
      S_RD: begin
        val_d   = ram_rdata_i;
        grp_d   = subid_groups(ram_rdata_i);
        state_d = S_GRP;
      end
      S_GRP: begin
        if (adv) begin
          emit   = 1'b1;
          e_byte = (grp_q > 3'd1) ? (grp_bits | GRP_MORE) : grp_bits;
          e_last = (grp_q == 3'd1) && (idx_nx == cnt_q);
          grp_d  = grp_q - 3'd1;
          if (grp_q == 3'd1) begin
            if (idx_nx == cnt_q) begin
              state_d = S_IDLE;
            end else begin
              idx_d   = idx_nx;
              state_d = S_RD;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // read data shows up in S_RD for the index chosen on the way in
  assign ram_raddr_o = idx_d[Aw-1:0];
  assign oid_done_o  = emit && e_last && oid_q && (state_q != S_IDLE);

  always_comb begin
    ov_d = ov_q;
    ob_d = ob_q;
    ol_d = ol_q;
    oe_d = oe_q;
    if (emit) begin
      ov_d = 1'b1;
      ob_d = e_byte;
      ol_d = e_last;
      oe_d = e_err;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    nb_q   <= nb_d;
    oid_q  <= oid_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    val_q  <= val_d;
    grp_q  <= grp_d;
    ob_q   <= ob_d;
    ol_q   <= ol_d;
    oe_q   <= oe_d;
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign last_o      = ol_q;
  assign error_o     = oe_q;

  `BV_ASSERT_IMPL(a_err_last, out_valid_o && error_o, last_o, "error byte not marked last")
  `BV_ASSERT_IMPL(a_grp_live, state_q == S_GRP, grp_q != 3'd0, "group walk with no group left")
  `BV_ASSERT_IMPL(a_pop_valid, q_pop_o, q_valid_i, "pop from empty command queue")
  `BV_ASSERT_IMPL(a_rd_range, state_q == S_RD, idx_q < cnt_q, "subid read past stored count")

endmodule

### bench/tb_ber_value_encoder_unit.sv
`timescale 1ns / 100ps
// testbench of ber_value_encoder_unit: directed and random requests on the input
// channel, every output byte checked against a behavioral tlv encoder in the bench
// depends on bvenc_pkg and the encoder rtl
module tb_ber_value_encoder_unit;
  import bvenc_pkg::*;

  localparam int unsigned MaxSubids   = MAX_SUBIDS_DEF;
  localparam int unsigned NumRandom   = 70;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned MaxMsgs     = 200;

  typedef struct {
    logic [1:0]  req;
    logic [31:0] value;
    logic [7:0]  tag;
    logic        last_subid;
    int unsigned gap;
  } request_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } tlv_byte_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic [1:0]  req_type_i   = '0;
  logic [31:0] value_i      = '0;
  logic [7:0]  type_tag_i   = '0;
  logic        last_subid_i = 1'b0;
  logic        out_ready_i  = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic        last_o;
  logic        error_o;

  request_t    pend_q[$];
  tlv_byte_t   tlv_byte_q[$];
  request_t    drv_item;

  // bench copy of the subid store
  logic [31:0] subid_mem [MaxSubids];
  int unsigned subid_cnt = 0;
  logic        subid_ovf = 1'b0;

  bit          in_calm  = 1'b0;
  bit          out_calm = 1'b0;
  bit          in_xfer  = 1'b0;
  bit          out_xfer = 1'b0;
  int          in_wait  = -1;
  int unsigned out_wait = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_fail = 0;
  int unsigned n_out  = 0;

  ber_value_encoder_unit #(
    .MaxSubids(MaxSubids)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .type_tag_i  (type_tag_i),
    .last_subid_i(last_subid_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .error_o     (error_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned b128_len(input logic [31:0] v);
    if (v >= 32'h1000_0000) return 5;
    if (v >= 32'h0020_0000) return 4;
    if (v >= 32'h0000_4000) return 3;
    if (v >= 32'h0000_0080) return 2;
    return 1;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom >> $urandom_range(1, 31);
      2:       return $urandom_range(0, 255);
      3:       return (32'h1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
      4:       return ~($urandom >> $urandom_range(8, 31));
      default: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
    endcase
  endfunction

  // one element into the expected byte stream, last mark on its final byte
  task automatic push_element(input logic [7:0] bytes [$], input logic err);
    tlv_byte_t b;
    for (int i = 0; i < bytes.size(); i++) begin
      b.data = bytes[i];
      b.last = (i == bytes.size() - 1);
      b.err  = err;
      tlv_byte_q.push_back(b);
    end
  endtask

  task automatic encode_request(input logic [1:0] req, input logic [31:0] v,
                                input logic [7:0] tag, input logic lastsub);
    logic [7:0]  bytes [$];
    int          sv;
    int unsigned nb;
    int unsigned gs;
    logic [31:0] w;
    logic [31:0] x;
    sv = v;
    case (req)
      REQ_SINT: begin
        if (sv < -8388608 || sv > 8388607) nb = 4;
        else if (sv < -32768 || sv > 32767) nb = 3;
        else if (sv < -128 || sv > 127) nb = 2;
        else nb = 1;
        bytes.push_back(TAG_INT);
        bytes.push_back(8'(nb));
        for (int k = nb; k > 0; k--) bytes.push_back(8'(v >> (8 * (k - 1))));
        push_element(bytes, 1'b0);
      end
      REQ_UINT: begin
        if (|v[31:24]) nb = 4;
        else if (|v[23:16]) nb = 3;
        else if (|v[15:8]) nb = 2;
        else nb = 1;
        bytes.push_back(tag);
        bytes.push_back(8'(nb));
        for (int k = nb; k > 0; k--) bytes.push_back(8'(v >> (8 * (k - 1))));
        push_element(bytes, 1'b0);
      end
      REQ_STR: begin
        bytes.push_back(TAG_OCTETS);
        if (v > 32'd65535) begin
          push_element(bytes, 1'b1);
        end else begin
          if (v > 32'd255) begin
            bytes.push_back(LEN_LONG2);
            bytes.push_back(v[15:8]);
          end else if (v > 32'd127) begin
            bytes.push_back(LEN_LONG1);
          end
          bytes.push_back(v[7:0]);
          push_element(bytes, 1'b0);
        end
      end
      default: begin
        if (subid_cnt < MaxSubids) begin
          subid_mem[subid_cnt] = v;
          subid_cnt++;
        end else begin
          subid_ovf = 1'b1;
        end
        if (lastsub) begin
          bytes.push_back(TAG_OID);
          if (subid_ovf) begin
            push_element(bytes, 1'b1);
          end else begin
            nb = 1;
            for (int i = 2; i < subid_cnt; i++) nb += b128_len(subid_mem[i]);
            // missing first or second subid counts as zero
            w = (subid_cnt > 0 ? subid_mem[0] : 32'h0) * 32'(OID_MUL)
                + (subid_cnt > 1 ? subid_mem[1] : 32'h0);
            bytes.push_back({1'b0, 7'(nb)});
            bytes.push_back(w[7:0]);
            for (int i = 2; i < subid_cnt; i++) begin
              x  = subid_mem[i];
              gs = b128_len(x);
              for (int g = gs; g > 0; g--) begin
                w = (x >> (7 * (g - 1))) & 32'h7f;
                bytes.push_back(g > 1 ? (w[7:0] | GRP_MORE) : w[7:0]);
              end
            end
            push_element(bytes, 1'b0);
          end
          subid_cnt = 0;
          subid_ovf = 1'b0;
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    n_fail++;
    if (n_fail <= MaxMsgs)
      $display("%0t mismatch on %s: got %02h, want %02h", $time, what, got, want);
  endtask

  task automatic check_byte();
    tlv_byte_t e;
    if (tlv_byte_q.size() == 0) begin
      report_mismatch("byte with nothing pending", out_byte_o, 8'h00);
    end else begin
      e = tlv_byte_q.pop_front();
      if (out_byte_o !== e.data) report_mismatch("out_byte", out_byte_o, e.data);
      if (last_o !== e.last) report_mismatch("last", 8'(last_o), 8'(e.last));
      if (error_o !== e.err) report_mismatch("error", 8'(error_o), 8'(e.err));
    end
  endtask

  task automatic queue_request(input logic [1:0] req, input logic [31:0] v,
                               input logic [7:0] tag, input logic ls);
    request_t r;
    r.req        = req;
    r.value      = v;
    r.tag        = tag;
    r.last_subid = ls;
    r.gap        = in_calm ? 0 : $urandom_range(0, 19);
    pend_q.push_back(r);
  endtask

  task automatic queue_scalar(input logic [1:0] req, input logic [31:0] v);
    queue_request(req, v, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic queue_subid(input logic [31:0] v, input logic ls);
    queue_request(REQ_OID, v, 8'($urandom_range(0, 255)), ls);
  endtask

  task automatic queue_rand_scalar();
    case ($urandom_range(0, 2))
      0: queue_scalar(REQ_SINT, rand_word());
      1: queue_scalar(REQ_UINT, rand_word());
      default: queue_scalar(REQ_STR, $urandom_range(0, 3) == 0 ? rand_word()
                                                               : $urandom_range(0, 70000));
    endcase
  endtask

  // n subids, the last one marked; n above the store depth overflows it
  task automatic queue_oid(input int unsigned n);
    bit wide;
    wide = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) queue_rand_scalar();
      queue_subid(wide ? ($urandom | 32'h1000_0000) : rand_word(), i == n - 1);
    end
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_xfer) begin
        if (pend_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else begin
          if (in_wait < 0) in_wait = pend_q[0].gap;
          if (in_wait > 0) begin
            in_wait--;
            in_valid_i <= 1'b0;
          end else begin
            drv_item = pend_q.pop_front();
            in_wait  = -1;
            req_type_i   <= drv_item.req;
            value_i      <= drv_item.value;
            type_tag_i   <= drv_item.tag;
            last_subid_i <= drv_item.last_subid;
            in_valid_i   <= 1'b1;
          end
        end
      end
    end
  end

  // output back-pressure, one stall drawn per byte
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_xfer) out_wait = out_calm ? 0 : $urandom_range(0, 19);
      if (out_wait > 0) begin
        out_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // monitor: predicts on input transfers, checks output transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_xfer  = in_valid_i && in_ready_o;
      out_xfer = out_valid_o && out_ready_i;
      if (in_xfer) encode_request(req_type_i, value_i, type_tag_i, last_subid_i);
      if (out_xfer) begin
        check_byte();
        n_out++;
        if (n_out % 40 == 0) out_calm = $urandom_range(0, 1);
      end
      quiet_cycles = (in_xfer || out_xfer) ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned n_dir;
    // signed integer size boundaries
    queue_scalar(REQ_SINT, 32'h0000_0000);
    queue_scalar(REQ_SINT, 32'h0000_007f);
    queue_scalar(REQ_SINT, 32'hffff_ff80);
    queue_scalar(REQ_SINT, 32'h0000_0080);
    queue_scalar(REQ_SINT, 32'hffff_ff7f);
    queue_scalar(REQ_SINT, 32'h0000_7fff);
    queue_scalar(REQ_SINT, 32'hffff_7fff);
    queue_scalar(REQ_SINT, 32'h007f_ffff);
    queue_scalar(REQ_SINT, 32'hff80_0000);
    queue_scalar(REQ_SINT, 32'h0080_0000);
    queue_scalar(REQ_SINT, 32'h8000_0000);
    // unsigned with explicit tags
    queue_request(REQ_UINT, 32'h0000_0000, 8'h41, 1'b0);
    queue_request(REQ_UINT, 32'h0000_0100, 8'h42, 1'b1);
    queue_request(REQ_UINT, 32'h00ff_ffff, 8'h43, 1'b0);
    queue_request(REQ_UINT, 32'hffff_ffff, 8'hff, 1'b1);
    // string length forms and the too-long error
    queue_scalar(REQ_STR, 32'd127);
    queue_scalar(REQ_STR, 32'd128);
    queue_scalar(REQ_STR, 32'd255);
    queue_scalar(REQ_STR, 32'd256);
    queue_scalar(REQ_STR, 32'd65535);
    queue_scalar(REQ_STR, 32'd65536);
    // single subid oid, then one with a scalar in the middle
    queue_subid(32'd2, 1'b1);
    queue_subid(32'd1, 1'b0);
    queue_subid(32'd3, 1'b0);
    queue_scalar(REQ_SINT, 32'hffff_fffe);
    queue_subid(32'hffff_ffff, 1'b0);
    queue_subid(32'd128, 1'b0);
    queue_subid(32'd16384, 1'b0);
    queue_subid(32'd6, 1'b1);
    n_dir = pend_q.size();

    while (pend_q.size() < n_dir + NumRandom) begin
      if ($urandom_range(0, 15) == 0) in_calm = ~in_calm;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: queue_rand_scalar();
        default: queue_oid($urandom_range(0, 7) == 0 ? $urandom_range(13, 15)
                                                     : $urandom_range(1, 12));
      endcase
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    fork
      begin
        while (pend_q.size() != 0 || in_valid_i) @(negedge clk_i);
        while (tlv_byte_q.size() != 0) @(negedge clk_i);
        repeat (DrainCycles) @(negedge clk_i);
      end
      while (quiet_cycles < QuietLimit) @(negedge clk_i);
    join_any

    if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no transfer for %0d cycles", QuietLimit);
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
